// ===== sv/pcg32rg_pkg.sv =====
// Package for the PCG32 XSH-RR range generator.
// Holds the payload and control types and the generator constants.
// No dependencies.
package pcg32rg_pkg;

  localparam logic [63:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
  localparam logic [32:0] RAW_FULL   = 33'h0_FFFF_FFFF;
  localparam logic [32:0] RAW_FULL2  = 33'h1_FFFF_FFFE;
  localparam logic [63:0] HALF_BIAS  = 64'h0000_0000_7FFF_FFFF;

  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [63:0]        load_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } pcg_in_t;

  typedef struct packed {
    logic [31:0]        raw_number;
    logic signed [31:0] ranged_value;
    logic [63:0]        state_value;
  } pcg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_INC,
    ST_PERM,
    ST_MAP,
    ST_DIV0,
    ST_DIV1,
    ST_DIV2,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    MUL_SLO_MLO,
    MUL_SHI_MLO,
    MUL_SLO_MHI,
    MUL_RAW_MAG
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load_state;
    mul_sel_t mul_sel;
    logic     acc_set;
    logic     acc_addhi;
    logic     adv_state;
    logic     perm;
    logic     div0;
    logic     div1;
    logic     div2;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       out_blocked;
  } dp_status_t;

endpackage

// ===== sv/pcg32rg_ctrl.sv =====
// Sequencer for the PCG32 range generator.
// Steps the datapath through advance, permute, map and output load.
// Depends on pcg32rg_pkg.
module pcg32rg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pcg32rg_pkg::dp_status_t sts,
  output pcg32rg_pkg::dp_cmd_t    cmd
);
  import pcg32rg_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MUL_SLO_MLO;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.load_state = (sts.opcode == OP_LOAD);
          state_next = (sts.opcode == OP_ADVANCE) ? ST_M0 : ST_PERM;
        end
      end
      ST_M0: begin
        cmd.mul_sel = MUL_SLO_MLO;
        state_next = ST_M1;
      end
      ST_M1: begin
        cmd.mul_sel = MUL_SHI_MLO;
        cmd.acc_set = 1'b1;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.mul_sel = MUL_SLO_MHI;
        cmd.acc_addhi = 1'b1;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.acc_addhi = 1'b1;
        state_next = ST_INC;
      end
      ST_INC: begin
        cmd.adv_state = 1'b1;
        state_next = ST_PERM;
      end
      ST_PERM: begin
        cmd.perm = 1'b1;
        state_next = ST_MAP;
      end
      ST_MAP: begin
        cmd.mul_sel = MUL_RAW_MAG;
        state_next = ST_DIV0;
      end
      ST_DIV0: begin
        cmd.div0 = 1'b1;
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.div1 = 1'b1;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.div2 = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_blocked) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pcg32rg_dp.sv =====
// Datapath for the PCG32 range generator: LCG state, shared 32x32
// multiplier, XSH-RR permutation, range mapping and output register.
// Depends on pcg32rg_pkg.
module pcg32rg_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [63:0]            cfg_wr_data,
  input  pcg32rg_pkg::pcg_in_t    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pcg32rg_pkg::pcg_out_t   out_data,
  input  pcg32rg_pkg::dp_cmd_t    cmd,
  output pcg32rg_pkg::dp_status_t sts
);
  import pcg32rg_pkg::*;

  logic [63:0] lcg;
  logic [63:0] inc;
  logic [63:0] acc;
  logic [63:0] mul_p;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31:0] raw;
  logic [31:0] mag;
  logic        neg;
  logic [63:0] n;
  logic [32:0] t;
  logic [31:0] q;
  logic [63:0] mix;
  logic [31:0] xs;
  logic [63:0] xs2;
  logic [31:0] perm_val;
  logic [31:0] diff;
  logic [1:0]  k;
  logic [31:0] off;

  always_comb begin
    mix = lcg ^ (lcg >> 18);
    xs = mix[58:27];
    xs2 = {xs, xs} >> lcg[63:59];
    perm_val = xs2[31:0];
    diff = hi - lo;
    if (t >= RAW_FULL2) begin
      k = 2'd2;
    end else if (t >= RAW_FULL) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    off = neg ? (32'd0 - q) : q;
    case (cmd.mul_sel)
      MUL_SLO_MLO: begin
        mul_a = lcg[31:0];
        mul_b = LCG_MULT[31:0];
      end
      MUL_SHI_MLO: begin
        mul_a = lcg[63:32];
        mul_b = LCG_MULT[31:0];
      end
      MUL_SLO_MHI: begin
        mul_a = lcg[31:0];
        mul_b = LCG_MULT[63:32];
      end
      MUL_RAW_MAG: begin
        mul_a = raw;
        mul_b = mag;
      end
      default: begin
        mul_a = raw;
        mul_b = mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inc <= 64'd1;
      lcg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        inc <= {cfg_wr_data[63:1], 1'b1};
      end
      if (cmd.capture && cmd.load_state) begin
        lcg <= in_data.load_value;
      end else if (cmd.adv_state) begin
        lcg <= acc + inc;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    if (cmd.capture) begin
      lo <= in_data.range_low;
      hi <= in_data.range_high;
    end
    if (cmd.acc_set) begin
      acc <= mul_p;
    end else if (cmd.acc_addhi) begin
      acc[63:32] <= acc[63:32] + mul_p[31:0];
    end
    if (cmd.perm) begin
      raw <= perm_val;
      neg <= diff[31];
      mag <= diff[31] ? (32'd0 - diff) : diff;
    end
    if (cmd.div0) begin
      n <= mul_p + HALF_BIAS;
    end
    if (cmd.div1) begin
      t <= {1'b0, n[63:32]} + {1'b0, n[31:0]};
    end
    if (cmd.div2) begin
      q <= n[63:32] + {30'd0, k};
    end
    if (cmd.out_load) begin
      out_data.raw_number <= raw;
      out_data.ranged_value <= off + lo;
      out_data.state_value <= lcg;
    end
  end

  assign sts.opcode = in_data.opcode;
  assign sts.out_blocked = out_valid && out_stall;

endmodule

// ===== sv/pcg32_range_generator.sv =====
// PCG32 XSH-RR random number generator with range mapping, top level.
// Input channel in_valid/in_stall/in_data carries opcode, load value and
// bounds; output channel out_valid/out_stall/out_data carries the raw
// 32-bit number, the mapped value and the 64-bit state.
// cfg_wr_en/cfg_wr_data write the stream increment (bit 0 forced high).
// One item is in work at a time. The result is registered after the
// permute, map and divide steps for peek and load, and after the LCG
// advance and those steps for advance; the next item is taken in the
// cycle after the result loads.
// The 64-bit LCG multiply runs as three passes of a shared 32x32
// multiplier, and the range mapping takes a fourth pass plus three
// add/compare steps for the exact divide by 2^32-1.
// The result waits in the output register while out_stall is high; a new
// item may be taken meanwhile, and its result is held back until the
// previous one transfers.
// Reset clears the state to zero and the increment to one, and empties
// the output register.
// Depends on pcg32rg_pkg, pcg32rg_ctrl and pcg32rg_dp.
module pcg32_range_generator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [63:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcg32rg_pkg::pcg_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcg32rg_pkg::pcg_out_t out_data
);
  import pcg32rg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  pcg32rg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcg32rg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_blocked)
    else $error("result loaded over a pending result");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (in_valid && !in_stall))
    else $error("capture outside an input transfer");

endmodule
